// ===== hw/rtl/tgnm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tgnm_pkg;

  // Default grid capacity
  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;

  // Field widths
  localparam int CFG_W   = 7;
  localparam int COORD_W = 6;
  localparam int ID_W    = 8;
  localparam int MASK_W  = 4;

  // Configuration register indexes and reset values
  localparam logic CFG_IDX_COLUMNS = 1'b0;
  localparam logic CFG_IDX_ROWS    = 1'b1;
  localparam logic [CFG_W-1:0] CFG_RESET_COLUMNS = 7'd64;
  localparam logic [CFG_W-1:0] CFG_RESET_ROWS    = 7'd64;

  // Neighbor mask bits
  localparam logic [MASK_W-1:0] MASK_NORTH = 4'b0001;
  localparam logic [MASK_W-1:0] MASK_WEST  = 4'b0010;
  localparam logic [MASK_W-1:0] MASK_EAST  = 4'b0100;
  localparam logic [MASK_W-1:0] MASK_SOUTH = 4'b1000;

  // Neighbor visiting order: north, south, west, east
  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_S = 2'd1,
    DIR_W = 2'd2,
    DIR_E = 2'd3
  } dir_t;

  // Neighbor slot counter runs 0..NB_COUNT
  localparam logic [2:0] NB_COUNT = 3'd4;

  // Microcode operations
  typedef enum logic [2:0] {
    OP_WRITE    = 3'd0,  // store new id at the edited cell
    OP_PROBE_C  = 3'd1,  // read a neighbor of the edited cell
    OP_PROBE_T  = 3'd2,  // read a neighbor of the current target cell
    OP_DRAIN    = 3'd3,  // let the last read land
    OP_SELECT   = 3'd4,  // pick next occupied neighbor or finish
    OP_EMIT_NB  = 3'd5,  // send a neighbor result
    OP_EMIT_CTR = 3'd6,  // send the edited cell result, last of run
    OP_EMIT_ERR = 3'd7   // send the coordinate error result
  } op_t;

  typedef logic [3:0] step_t;

  // Program addresses
  localparam step_t ST_WRITE  = 4'd0;
  localparam step_t ST_PC_N   = 4'd1;
  localparam step_t ST_PC_S   = 4'd2;
  localparam step_t ST_PC_W   = 4'd3;
  localparam step_t ST_PC_E   = 4'd4;
  localparam step_t ST_PC_DR  = 4'd5;
  localparam step_t ST_SELECT = 4'd6;
  localparam step_t ST_PT_N   = 4'd7;
  localparam step_t ST_PT_S   = 4'd8;
  localparam step_t ST_PT_W   = 4'd9;
  localparam step_t ST_PT_E   = 4'd10;
  localparam step_t ST_PT_DR  = 4'd11;
  localparam step_t ST_EMIT   = 4'd12;
  localparam step_t ST_CTR    = 4'd13;
  localparam step_t ST_ERR    = 4'd14;

  typedef struct packed {
    op_t   op;
    dir_t  dir;
    step_t jmp;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    logic active;
    op_t  op;
    dir_t dir;
    dir_t nb;
    logic tgt_load;
    logic emit;
  } seq_ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic coord_err;
    logic nb_occ;
    logic out_free;
  } seq_stat_t;

  // Control store
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t uc;
    uc = '{op: OP_EMIT_ERR, dir: DIR_N, jmp: ST_WRITE};
    case (step)
      ST_WRITE:  uc = '{op: OP_WRITE,    dir: DIR_N, jmp: ST_ERR};
      ST_PC_N:   uc = '{op: OP_PROBE_C,  dir: DIR_N, jmp: ST_WRITE};
      ST_PC_S:   uc = '{op: OP_PROBE_C,  dir: DIR_S, jmp: ST_WRITE};
      ST_PC_W:   uc = '{op: OP_PROBE_C,  dir: DIR_W, jmp: ST_WRITE};
      ST_PC_E:   uc = '{op: OP_PROBE_C,  dir: DIR_E, jmp: ST_WRITE};
      ST_PC_DR:  uc = '{op: OP_DRAIN,    dir: DIR_N, jmp: ST_WRITE};
      ST_SELECT: uc = '{op: OP_SELECT,   dir: DIR_N, jmp: ST_CTR};
      ST_PT_N:   uc = '{op: OP_PROBE_T,  dir: DIR_N, jmp: ST_WRITE};
      ST_PT_S:   uc = '{op: OP_PROBE_T,  dir: DIR_S, jmp: ST_WRITE};
      ST_PT_W:   uc = '{op: OP_PROBE_T,  dir: DIR_W, jmp: ST_WRITE};
      ST_PT_E:   uc = '{op: OP_PROBE_T,  dir: DIR_E, jmp: ST_WRITE};
      ST_PT_DR:  uc = '{op: OP_DRAIN,    dir: DIR_N, jmp: ST_WRITE};
      ST_EMIT:   uc = '{op: OP_EMIT_NB,  dir: DIR_N, jmp: ST_SELECT};
      ST_CTR:    uc = '{op: OP_EMIT_CTR, dir: DIR_N, jmp: ST_WRITE};
      ST_ERR:    uc = '{op: OP_EMIT_ERR, dir: DIR_N, jmp: ST_WRITE};
      default:   uc = '{op: OP_EMIT_ERR, dir: DIR_N, jmp: ST_WRITE};
    endcase
    return uc;
  endfunction

  // Mask bit for a direction
  function automatic logic [MASK_W-1:0] dir_bit(input dir_t dir);
    logic [MASK_W-1:0] m;
    m = '0;
    case (dir)
      DIR_N:   m = MASK_NORTH;
      DIR_S:   m = MASK_SOUTH;
      DIR_W:   m = MASK_WEST;
      DIR_E:   m = MASK_EAST;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tile_grid_neighbor_mask_update.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Tile grid with 4-neighbor bitmask update. Each input beat stores a tile id at
// (column, row) and returns one result beat per occupied neighbor (north, south,
// west, east) with its recomputed mask, then one for the edited cell itself,
// marked last_of_run. Mask bits: north 1, west 2, east 4, south 8; cells outside
// grid_columns x grid_rows count as empty. Coordinates outside the configured
// grid return a single beat with coord_error and last_of_run set, nothing stored.
// After an accepted beat the input stays stalled until its run has ended, so a
// new edit is taken only once the last one is through. A run grows with the
// number of occupied neighbors; an out-of-grid edit ends after its error beat,
// and result stalls lengthen a run. Runs are set by the single port of the
// tile id memory, which a small microcode program walks one read per cycle.
// After reset a clearing pass zeroes all MAX_COLUMNS*MAX_ROWS cells (4096 at
// the default size) with in_stall held high. Configuration writes are taken
// only between edits, and a pending write holds off the input beat.
module tile_grid_neighbor_mask_update import tgnm_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [COORD_W-1:0] in_cell_column,
  input  wire logic [COORD_W-1:0] in_cell_row,
  input  wire logic [ID_W-1:0]    in_new_tile_id,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [COORD_W-1:0]      out_column,
  output logic [COORD_W-1:0]      out_row,
  output logic [ID_W-1:0]         out_tile_id,
  output logic [MASK_W-1:0]       out_mask,
  output logic                    out_last_of_run,
  output logic                    out_coord_error,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data
);

  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = CFG_W;

  // Step a coordinate pair one cell in a direction (7-bit wrap makes -1 = 127)
  function automatic logic [2*PW-1:0] step_coord(input logic [PW-1:0] c,
                                                 input logic [PW-1:0] r,
                                                 input dir_t dir);
    logic [PW-1:0] nc;
    logic [PW-1:0] nr;
    nc = c;
    nr = r;
    case (dir)
      DIR_N:   nr = r - PW'(1);
      DIR_S:   nr = r + PW'(1);
      DIR_W:   nc = c - PW'(1);
      DIR_E:   nc = c + PW'(1);
      default: nc = c;
    endcase
    return {nc, nr};
  endfunction

  seq_ctrl_t ctrl;
  seq_stat_t stat;

  // Configuration registers
  logic [CFG_W-1:0] cols_r, rows_r;
  logic [CFG_W-1:0] used_cols, used_rows;

  // Edit registers
  logic [COORD_W-1:0] col_r, row_r;
  logic [ID_W-1:0]    id_r;

  // Walk state
  logic [PW-1:0]     tgt_c_r, tgt_r_r;
  logic [MASK_W-1:0] cmask_r, acc_r;
  logic [ID_W-1:0]   nid_r [4];
  logic              pend_vld_r, pend_in_r, pend_ctr_r;
  dir_t              pend_dir_r;

  // Memory and clearing pass
  logic [ID_W-1:0] id_mem [CELLS];
  logic [ID_W-1:0] mem_q_r;
  logic [AW-1:0]   clr_addr_r;
  logic            clr_busy_r;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_addr;
  logic [ID_W-1:0] mem_wd;

  // Probe address
  logic [PW-1:0]   base_c, base_r, pc, pr, nb_col, nb_row;
  logic            p_in, is_probe, hit;
  logic [AW-1:0]   p_addr, ctr_addr;

  // Output stage
  logic out_valid_r;
  logic in_accept;

  assign cfg_ready = ~ctrl.active;
  assign in_stall  = ctrl.active | clr_busy_r | cfg_valid;
  assign in_accept = in_valid & ~in_stall;
  assign out_valid = out_valid_r;

  // Register values above capacity saturate
  assign used_cols = (int'(cols_r) > MAX_COLUMNS) ? PW'(MAX_COLUMNS) : cols_r;
  assign used_rows = (int'(rows_r) > MAX_ROWS)    ? PW'(MAX_ROWS)    : rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= CFG_RESET_COLUMNS;
      rows_r <= CFG_RESET_ROWS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_COLUMNS: cols_r <= cfg_data;
        CFG_IDX_ROWS:    rows_r <= cfg_data;
        default:         cols_r <= cols_r;
      endcase
    end
  end

  // Latch the edit
  always_ff @(posedge clk) begin
    if (in_accept) begin
      col_r <= in_cell_column;
      row_r <= in_cell_row;
      id_r  <= in_new_tile_id;
    end
  end

  // Status back to the sequencer
  always_comb begin
    stat.coord_err = !((PW'(col_r) < used_cols) && (PW'(row_r) < used_rows));
    stat.nb_occ    = |(cmask_r & dir_bit(ctrl.nb));
    stat.out_free  = !out_valid_r || !out_stall;
  end

  tgnm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_accept),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Probe coordinate and address
  always_comb begin
    base_c     = (ctrl.op == OP_PROBE_C) ? PW'(col_r) : tgt_c_r;
    base_r     = (ctrl.op == OP_PROBE_C) ? PW'(row_r) : tgt_r_r;
    {pc, pr}   = step_coord(base_c, base_r, ctrl.dir);
    {nb_col, nb_row} = step_coord(PW'(col_r), PW'(row_r), ctrl.nb);
    p_in       = (pc < used_cols) && (pr < used_rows);
    p_addr     = p_in ? AW'(int'(pr) * MAX_COLUMNS + int'(pc)) : '0;
    ctr_addr   = AW'(int'(row_r) * MAX_COLUMNS + int'(col_r));
    is_probe   = ctrl.active && ((ctrl.op == OP_PROBE_C) || (ctrl.op == OP_PROBE_T));
  end

  // Single memory port: clearing pass, edit write or neighbor read
  always_comb begin
    mem_we   = clr_busy_r ||
               (ctrl.active && (ctrl.op == OP_WRITE) && !stat.coord_err);
    mem_re   = is_probe && p_in;
    mem_wd   = clr_busy_r ? '0 : id_r;
    if (clr_busy_r) begin
      mem_addr = clr_addr_r;
    end else if (ctrl.op == OP_WRITE) begin
      mem_addr = ctr_addr;
    end else begin
      mem_addr = p_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      id_mem[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= id_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(CELLS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Read in flight; its data lands in the following cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else begin
      pend_vld_r <= is_probe;
    end
  end

  always_ff @(posedge clk) begin
    pend_in_r  <= p_in;
    pend_ctr_r <= (ctrl.op == OP_PROBE_C);
    pend_dir_r <= ctrl.dir;
  end

  assign hit = pend_vld_r && pend_in_r && (mem_q_r != '0);

  // Occupancy masks and neighbor ids
  always_ff @(posedge clk) begin
    if (ctrl.active && (ctrl.op == OP_WRITE)) begin
      cmask_r <= '0;
    end else if (hit && pend_ctr_r) begin
      cmask_r <= cmask_r | dir_bit(pend_dir_r);
    end
    if (pend_vld_r && pend_ctr_r) begin
      nid_r[pend_dir_r] <= mem_q_r;
    end
    if (ctrl.tgt_load) begin
      acc_r   <= '0;
      tgt_c_r <= nb_col;
      tgt_r_r <= nb_row;
    end else if (hit && !pend_ctr_r) begin
      acc_r <= acc_r | dir_bit(pend_dir_r);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      case (ctrl.op)
        OP_EMIT_NB: begin
          out_column      <= tgt_c_r[COORD_W-1:0];
          out_row         <= tgt_r_r[COORD_W-1:0];
          out_tile_id     <= nid_r[ctrl.nb];
          out_mask        <= acc_r;
          out_last_of_run <= 1'b0;
          out_coord_error <= 1'b0;
        end
        OP_EMIT_CTR: begin
          out_column      <= col_r;
          out_row         <= row_r;
          out_tile_id     <= id_r;
          out_mask        <= cmask_r;
          out_last_of_run <= 1'b1;
          out_coord_error <= 1'b0;
        end
        default: begin
          out_column      <= col_r;
          out_row         <= row_r;
          out_tile_id     <= '0;
          out_mask        <= '0;
          out_last_of_run <= 1'b1;
          out_coord_error <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tgnm_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tgnm_seq import tgnm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire seq_stat_t stat,
  output seq_ctrl_t      ctrl
);

  logic       busy_r, busy_nxt;
  step_t      step_r, step_nxt;
  logic [2:0] nb_r, nb_nxt;
  ucode_t     uc;
  logic       nb_done;

  assign uc      = ucode_rom(step_r);
  assign nb_done = (nb_r == NB_COUNT);

  // Control word out to the datapath
  always_comb begin
    ctrl.active   = busy_r;
    ctrl.op       = uc.op;
    ctrl.dir      = uc.dir;
    ctrl.nb       = dir_t'(nb_r[1:0]);
    ctrl.tgt_load = busy_r && (uc.op == OP_SELECT) && !nb_done && stat.nb_occ;
    ctrl.emit     = busy_r && stat.out_free &&
                    ((uc.op == OP_EMIT_NB) || (uc.op == OP_EMIT_CTR) ||
                     (uc.op == OP_EMIT_ERR));
  end

  // Step counter and jumps
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    nb_nxt   = nb_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        step_nxt = ST_WRITE;
        nb_nxt   = '0;
      end
    end else begin
      case (uc.op)
        OP_WRITE: begin
          step_nxt = stat.coord_err ? uc.jmp : step_r + 1'b1;
        end
        OP_SELECT: begin
          if (nb_done) begin
            step_nxt = uc.jmp;
          end else if (!stat.nb_occ) begin
            nb_nxt = nb_r + 1'b1;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
        OP_EMIT_NB: begin
          if (stat.out_free) begin
            nb_nxt   = nb_r + 1'b1;
            step_nxt = uc.jmp;
          end
        end
        OP_EMIT_CTR, OP_EMIT_ERR: begin
          if (stat.out_free) begin
            busy_nxt = 1'b0;
          end
        end
        default: begin
          step_nxt = step_r + 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= ST_WRITE;
      nb_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      nb_r   <= nb_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tgnm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tgnm_checker import tgnm_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [COORD_W-1:0] out_column,
  input wire logic [COORD_W-1:0] out_row,
  input wire logic [ID_W-1:0]    out_tile_id,
  input wire logic [MASK_W-1:0]  out_mask,
  input wire logic               out_last_of_run,
  input wire logic               out_coord_error
);

  // An accepted edit keeps the input side closed the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off after an accepted beat");

  // An error beat closes its run
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_coord_error |-> out_last_of_run)
    else $error("coordinate error beat without last_of_run");

  // An error beat carries no tile and no mask
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_coord_error |-> (out_tile_id == '0) && (out_mask == '0))
    else $error("coordinate error beat with tile data");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_column) &&
      $stable(out_row) && $stable(out_tile_id) && $stable(out_mask) &&
      $stable(out_last_of_run) && $stable(out_coord_error))
    else $error("stalled result beat changed");

endmodule

bind tile_grid_neighbor_mask_update tgnm_checker u_tgnm_checker (.*);

`default_nettype wire

// ===== tb/sv/tile_grid_neighbor_mask_update_tb.sv =====
`timescale 1ns / 1ps

module tile_grid_neighbor_mask_update_tb;
  import tgnm_pkg::*;

  localparam int CELLS        = DEF_MAX_COLUMNS * DEF_MAX_ROWS;
  // the stall limit covers the clearing pass after reset and a hold-off
  localparam int STALL_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 48;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [ID_W-1:0]    tile_id;
    logic [MASK_W-1:0]  mask;
    logic               last_of_run;
    logic               coord_error;
  } tile_update_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [COORD_W-1:0]  in_cell_column = '0;
  logic [COORD_W-1:0]  in_cell_row = '0;
  logic [ID_W-1:0]     in_new_tile_id = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [COORD_W-1:0]  out_column;
  logic [COORD_W-1:0]  out_row;
  logic [ID_W-1:0]     out_tile_id;
  logic [MASK_W-1:0]   out_mask;
  logic                out_last_of_run;
  logic                out_coord_error;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = CFG_IDX_COLUMNS;
  logic [CFG_W-1:0]    cfg_data = '0;

  // shadow grid and registers
  bit [ID_W-1:0] tile_ids [CELLS];
  int            grid_cols_cfg = CFG_RESET_COLUMNS;
  int            grid_rows_cfg = CFG_RESET_ROWS;
  tile_update_t  pending_updates [$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req_seq = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  tile_grid_neighbor_mask_update i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cell_column  (in_cell_column),
    .in_cell_row     (in_cell_row),
    .in_new_tile_id  (in_new_tile_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_column      (out_column),
    .out_row         (out_row),
    .out_tile_id     (out_tile_id),
    .out_mask        (out_mask),
    .out_last_of_run (out_last_of_run),
    .out_coord_error (out_coord_error),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Mask predictor
  // ---------------------------------------------------------------------------

  // register values above capacity saturate
  function automatic int used_columns();
    return grid_cols_cfg > DEF_MAX_COLUMNS ? DEF_MAX_COLUMNS : grid_cols_cfg;
  endfunction

  function automatic int used_rows();
    return grid_rows_cfg > DEF_MAX_ROWS ? DEF_MAX_ROWS : grid_rows_cfg;
  endfunction

  function automatic bit in_grid(int c, int r);
    return c >= 0 && r >= 0 && c < used_columns() && r < used_rows();
  endfunction

  // cells beyond the configured size keep their id but read as empty
  function automatic bit occupied(int c, int r);
    return in_grid(c, r) && tile_ids[r * DEF_MAX_COLUMNS + c] != 0;
  endfunction

  function automatic logic [MASK_W-1:0] neighbor_mask(int c, int r);
    logic [MASK_W-1:0] m;
    m = '0;
    if (occupied(c, r - 1)) m |= MASK_NORTH;
    if (occupied(c, r + 1)) m |= MASK_SOUTH;
    if (occupied(c - 1, r)) m |= MASK_WEST;
    if (occupied(c + 1, r)) m |= MASK_EAST;
    return m;
  endfunction

  function automatic void push_update(int c, int r);
    tile_update_t u;
    u.column      = c[COORD_W-1:0];
    u.row         = r[COORD_W-1:0];
    u.tile_id     = tile_ids[r * DEF_MAX_COLUMNS + c];
    u.mask        = neighbor_mask(c, r);
    u.last_of_run = 1'b0;
    u.coord_error = 1'b0;
    pending_updates.push_back(u);
  endfunction

  // one edit: neighbors north, south, west, east, then the edited cell; out of grid, one error beat
  function automatic void predict_edit(int c, int r, logic [ID_W-1:0] id);
    tile_update_t u;
    if (!in_grid(c, r)) begin
      u = '{column: c[COORD_W-1:0], row: r[COORD_W-1:0], tile_id: '0, mask: '0,
            last_of_run: 1'b1, coord_error: 1'b1};
      pending_updates.push_back(u);
      return;
    end
    tile_ids[r * DEF_MAX_COLUMNS + c] = id;
    if (occupied(c, r - 1)) push_update(c, r - 1);
    if (occupied(c, r + 1)) push_update(c, r + 1);
    if (occupied(c - 1, r)) push_update(c - 1, r);
    if (occupied(c + 1, r)) push_update(c + 1, r);
    push_update(c, r);
    u = pending_updates.pop_back();
    u.last_of_run = 1'b1;
    pending_updates.push_back(u);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [ID_W-1:0] want,
                             input logic [ID_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    tile_update_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_updates.size() == 0) begin
        $error("result beat with nothing expected: col %0d row %0d id %0d",
               out_column, out_row, out_tile_id);
        errors++;
      end else begin
        want = pending_updates.pop_front();
        check_field("out_column", ID_W'(want.column), ID_W'(out_column));
        check_field("out_row", ID_W'(want.row), ID_W'(out_row));
        check_field("out_tile_id", want.tile_id, out_tile_id);
        check_field("out_mask", ID_W'(want.mask), ID_W'(out_mask));
        check_field("out_last_of_run", ID_W'(want.last_of_run),
                    ID_W'(out_last_of_run));
        check_field("out_coord_error", ID_W'(want.coord_error),
                    ID_W'(out_coord_error));
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_seen != hold_req_seq) begin
      hold_seen <= hold_req_seq;
      hold_cnt  <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic send_edit(input int c, input int r, input int id);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cell_column <= c[COORD_W-1:0];
    in_cell_row    <= r[COORD_W-1:0];
    in_new_tile_id <= id[ID_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_edit(c, r, id[ID_W-1:0]);
  endtask

  // drain, then write both size registers back to back
  task automatic set_grid(input int cols, input int rows);
    in_valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_COLUMNS;
    cfg_data  <= cols[CFG_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    grid_cols_cfg = cols & 'h7f;
    cfg_index <= CFG_IDX_ROWS;
    cfg_data  <= rows[CFG_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    grid_rows_cfg = rows & 'h7f;
    cfg_valid <= 1'b0;
  endtask

  // corners and field extremes at the reset size
  task automatic test_default_grid();
    send_edit(0, 0, 255);
    send_edit(63, 63, 1);
    send_edit(63, 0, 128);
    send_edit(1, 0, 7);
    send_edit(0, 1, 0);
  endtask

  // full plus shape: results come north, south, west, east, then center
  task automatic test_neighbor_order();
    send_edit(20, 29, 1);
    send_edit(20, 31, 2);
    send_edit(19, 30, 3);
    send_edit(21, 30, 4);
    send_edit(20, 30, 9);
    send_edit(20, 30, 0);
    send_edit(20, 29, 0);
  endtask

  // coordinates past the configured size are rejected, those just inside are taken
  task automatic test_coord_errors();
    set_grid(5, 3);
    send_edit(5, 0, 1);
    send_edit(0, 3, 1);
    send_edit(63, 63, 255);
    send_edit(4, 2, 9);
    send_edit(3, 2, 1);
  endtask

  // cell left outside after shrinking counts as empty
  task automatic test_shrunk_grid();
    set_grid(64, 64);
    send_edit(10, 5, 3);
    set_grid(10, 6);
    send_edit(9, 5, 4);
  endtask

  // zero size, saturation above capacity, single cell
  task automatic test_register_extremes();
    set_grid(0, 5);
    send_edit(0, 0, 1);
    set_grid(5, 0);
    send_edit(0, 0, 1);
    set_grid(127, 127);
    send_edit(63, 63, 2);
    send_edit(63, 62, 5);
    set_grid(1, 1);
    send_edit(0, 0, 8);
    send_edit(1, 0, 8);
    send_edit(0, 0, 0);
  endtask

  // random edits, mostly packed into a small window so neighbors are common
  task automatic test_random_edits(input int count, input int cols, input int rows,
                                   input int send_pct, input int recv_pct);
    int span_c, span_r, base_c, base_r, c, r, id;
    set_grid(cols, rows);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    span_c = used_columns() < 6 ? used_columns() : 6;
    span_r = used_rows() < 6 ? used_rows() : 6;
    base_c = 0;
    base_r = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        base_c = $urandom_range(used_columns() - span_c);
        base_r = $urandom_range(used_rows() - span_r);
      end
      if ($urandom_range(99) < 12) begin
        c = $urandom_range(63);
        r = $urandom_range(63);
      end else begin
        c = base_c + $urandom_range(span_c - 1);
        r = base_r + $urandom_range(span_r - 1);
      end
      id = ($urandom_range(99) < 25) ? 0 : $urandom_range(255, 1);
      send_edit(c, r, id);
    end
  endtask

  // receiver holds off while edits keep coming, so the input backs up
  task automatic test_backpressure();
    set_grid(3, 3);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req_seq++;
    for (int i = 0; i < 14; i++) begin
      send_edit($urandom_range(2), $urandom_range(2), $urandom_range(255, 1));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_default_grid();
    test_neighbor_order();
    test_coord_errors();
    test_shrunk_grid();
    test_register_extremes();
    test_backpressure();
    test_random_edits(70, 8, 8, 0, 0);
    test_random_edits(80, 4, 6, 54, 0);
    test_random_edits(90, 64, 64, 0, 54);
    test_random_edits(80, 127, 3, 6, 6);
    test_random_edits(70, 7, 64, 0, 0);

    in_valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
